// ===== hw/rtl/mqtt_inbound_packet_parser_defines.svh =====
// ---------------------------------------------------------------------------
// MQTT inbound packet parser: assertion macros
// Shared property forms for the parser's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef MQTT_INBOUND_PACKET_PARSER_DEFINES_SVH
`define MQTT_INBOUND_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define MIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define MIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mip_pkg.sv =====
// ---------------------------------------------------------------------------
// MQTT inbound packet parser: package
// Widths, event and packet-type codes, the front-to-back command record and
// the end-of-packet classification shared by the parser modules.
// ---------------------------------------------------------------------------
package mip_pkg;

    // Fixed sizes
    localparam int LENGTH_DIGITS_MAX = 4;
    localparam int LEN_W             = 28;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_ADDR_W        = 3;
    localparam int CMD_FIFO_DEPTH    = 4;

    localparam logic [LEN_W-1:0] MAX_PKT_RESET = 28'd4096;

    // Configuration register indexes
    localparam logic [0:0] CFG_IDX_MAX_PKT = 1'b0;

    // Result event codes
    localparam logic [3:0] EV_TOPIC           = 4'd0;
    localparam logic [3:0] EV_PAYLOAD         = 4'd1;
    localparam logic [3:0] EV_PUB_DONE        = 4'd2;
    localparam logic [3:0] EV_CONNACK_OK      = 4'd3;
    localparam logic [3:0] EV_CONNACK_SHORT   = 4'd4;
    localparam logic [3:0] EV_CONNACK_REFUSED = 4'd5;
    localparam logic [3:0] EV_MALFORMED       = 4'd6;
    localparam logic [3:0] EV_OVERSIZED       = 4'd7;
    localparam logic [3:0] EV_IGNORED         = 4'd8;

    // Control packet types (high nibble of the first byte)
    localparam logic [3:0] PKT_CONNACK = 4'h2;
    localparam logic [3:0] PKT_PUBLISH = 4'h3;

    // One accepted byte's worth of results: one or two events
    typedef struct packed {
        logic        two;
        logic [3:0]  ev0;
        logic [3:0]  ev1;
        logic [7:0]  data;
        logic [3:0]  ptype;
        logic        qos1;
        logic        retain;
        logic [15:0] id;
        logic [15:0] topic_len;
    } t_cmd;

    // Event reported when a packet ends
    function automatic logic [3:0] f_finish_event(input logic [3:0] ptype,
                                                  input logic       drop,
                                                  input logic       len_lt2,
                                                  input logic       rc_nz);
        logic [3:0] ev;
        ev = EV_IGNORED;
        if (ptype == PKT_PUBLISH) begin
            ev = drop ? EV_IGNORED : EV_PUB_DONE;
        end else if (ptype == PKT_CONNACK) begin
            if (len_lt2) begin
                ev = EV_CONNACK_SHORT;
            end else if (rc_nz) begin
                ev = EV_CONNACK_REFUSED;
            end else begin
                ev = EV_CONNACK_OK;
            end
        end
        return ev;
    endfunction

endpackage

// ===== hw/rtl/mip_front.sv =====
// ---------------------------------------------------------------------------
// MQTT inbound packet parser: front end
// Parses the fixed header, remaining-length varint and body one byte per
// cycle when accepted, handing each byte's events to the command queue.
// ---------------------------------------------------------------------------
module mip_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_rx_byte,
    input  logic [mip_pkg::LEN_W-1:0]  i_max_pkt,
    output logic                       o_cmd_valid,
    output mip_pkg::t_cmd              o_cmd,
    output logic                       o_halted
);
    import mip_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic [1:0]       r_phase,      n_phase;
    logic [7:0]       r_first_byte, n_first_byte;
    logic [LEN_W-1:0] r_len_val,    n_len_val;
    logic [2:0]       r_len_dig,    n_len_dig;
    logic [LEN_W-1:0] r_body_pos,   n_body_pos;
    logic [15:0]      r_topic_len,  n_topic_len;
    logic [15:0]      r_id,         n_id;
    logic [7:0]       r_ret_code,   n_ret_code;
    logic             r_drop,       n_drop;
    logic             r_halted,     n_halted;

    logic [LEN_W-1:0] len_digit;
    logic [LEN_W-1:0] len_acc;
    logic [2:0]       dig_next;
    logic [LEN_W:0]   pkt_total;
    logic             len_too_big;
    logic [15:0]      topic_chk;
    logic [LEN_W-1:0] topic_chk2;
    logic [LEN_W-1:0] topic_chk4;
    logic [LEN_W-1:0] topic_end;
    logic [LEN_W-1:0] id_end;
    logic [LEN_W-1:0] body_next;
    logic             is_pub;
    logic             is_connack;
    logic             qos1;
    logic             emit_data;
    logic [3:0]       data_ev;
    logic             emit_fin;
    logic [3:0]       fin_ev;

    // Varint digit placed at its weight
    always_comb begin
        len_digit = '0;
        if (r_len_dig < 3'(LENGTH_DIGITS_MAX)) begin
            case (r_len_dig[1:0])
                2'd0:    len_digit = LEN_W'(i_rx_byte[6:0]);
                2'd1:    len_digit = LEN_W'({i_rx_byte[6:0], 7'b0});
                2'd2:    len_digit = LEN_W'({i_rx_byte[6:0], 14'b0});
                2'd3:    len_digit = LEN_W'({i_rx_byte[6:0], 21'b0});
                default: len_digit = '0;
            endcase
        end
    end

    assign len_acc     = r_len_val | len_digit;
    assign dig_next    = r_len_dig + 3'd1;
    assign pkt_total   = (LEN_W+1)'(len_acc) + (LEN_W+1)'(dig_next) + (LEN_W+1)'(1);
    assign len_too_big = pkt_total > {1'b0, i_max_pkt};

    // Body position checks
    assign topic_chk  = {r_topic_len[15:8], i_rx_byte};
    assign topic_chk2 = LEN_W'(topic_chk) + LEN_W'(2);
    assign topic_chk4 = LEN_W'(topic_chk) + LEN_W'(4);
    assign topic_end  = LEN_W'(r_topic_len) + LEN_W'(2);
    assign id_end     = LEN_W'(r_topic_len) + LEN_W'(4);
    assign body_next  = r_body_pos + LEN_W'(1);

    assign is_pub     = r_first_byte[7:4] == PKT_PUBLISH;
    assign is_connack = r_first_byte[7:4] == PKT_CONNACK;
    assign qos1       = r_first_byte[2:1] == 2'b01;

    // Per-byte parse step
    always_comb begin
        n_phase      = r_phase;
        n_first_byte = r_first_byte;
        n_len_val    = r_len_val;
        n_len_dig    = r_len_dig;
        n_body_pos   = r_body_pos;
        n_topic_len  = r_topic_len;
        n_id         = r_id;
        n_ret_code   = r_ret_code;
        n_drop       = r_drop;
        n_halted     = r_halted;
        emit_data    = 1'b0;
        data_ev      = EV_TOPIC;
        emit_fin     = 1'b0;
        fin_ev       = EV_IGNORED;

        if (i_accept && !r_halted) begin
            case (r_phase)
                PH_LENGTH: begin
                    n_len_val = len_acc;
                    n_len_dig = dig_next;
                    if (i_rx_byte[7]) begin
                        if (dig_next >= 3'(LENGTH_DIGITS_MAX)) begin
                            n_halted = 1'b1;
                            emit_fin = 1'b1;
                            fin_ev   = EV_MALFORMED;
                        end
                    end else if (len_too_big) begin
                        n_halted = 1'b1;
                        emit_fin = 1'b1;
                        fin_ev   = EV_OVERSIZED;
                    end else begin
                        n_phase    = PH_BODY;
                        n_body_pos = '0;
                        n_drop     = is_pub && (len_acc < LEN_W'(2));
                        if (len_acc == '0) begin
                            emit_fin = 1'b1;
                            fin_ev   = f_finish_event(r_first_byte[7:4], n_drop, 1'b1,
                                                      r_ret_code != 8'h00);
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                PH_BODY: begin
                    if (is_pub && !r_drop) begin
                        if (r_body_pos == '0) begin
                            n_topic_len = {i_rx_byte, 8'h00};
                        end else if (r_body_pos == LEN_W'(1)) begin
                            n_topic_len = topic_chk;
                            if (topic_chk2 > r_len_val || (qos1 && topic_chk4 > r_len_val)) begin
                                n_drop = 1'b1;
                            end
                        end else if (r_body_pos < topic_end) begin
                            emit_data = 1'b1;
                            data_ev   = EV_TOPIC;
                        end else if (qos1 && r_body_pos < id_end) begin
                            if (r_body_pos == topic_end) begin
                                n_id = {i_rx_byte, 8'h00};
                            end else begin
                                n_id = {r_id[15:8], i_rx_byte};
                            end
                        end else begin
                            emit_data = 1'b1;
                            data_ev   = EV_PAYLOAD;
                        end
                    end else if (is_connack && r_body_pos == LEN_W'(1)) begin
                        n_ret_code = i_rx_byte;
                    end
                    n_body_pos = body_next;
                    if (body_next >= r_len_val) begin
                        emit_fin = 1'b1;
                        fin_ev   = f_finish_event(r_first_byte[7:4], n_drop,
                                                  r_len_val < LEN_W'(2), n_ret_code != 8'h00);
                        n_phase  = PH_IDLE;
                    end
                end
                default: begin
                    n_first_byte = i_rx_byte;
                    n_len_val    = '0;
                    n_len_dig    = '0;
                    n_body_pos   = '0;
                    n_topic_len  = '0;
                    n_id         = '0;
                    n_ret_code   = '0;
                    n_drop       = 1'b0;
                    n_phase      = PH_LENGTH;
                end
            endcase

            // A refused or short connack stops the parser
            if (emit_fin && (fin_ev inside {EV_CONNACK_SHORT, EV_CONNACK_REFUSED})) begin
                n_halted = 1'b1;
            end
        end
    end

    // Command record for the back end
    always_comb begin
        o_cmd_valid     = emit_data || emit_fin;
        o_cmd.two       = emit_data && emit_fin;
        o_cmd.ev0       = emit_data ? data_ev : fin_ev;
        o_cmd.ev1       = fin_ev;
        o_cmd.data      = emit_data ? i_rx_byte : 8'h00;
        o_cmd.ptype     = r_first_byte[7:4];
        o_cmd.qos1      = qos1;
        o_cmd.retain    = r_first_byte[0];
        o_cmd.id        = n_id;
        o_cmd.topic_len = n_topic_len;
    end

    assign o_halted = r_halted;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_first_byte <= '0;
            r_len_val    <= '0;
            r_len_dig    <= '0;
            r_body_pos   <= '0;
            r_topic_len  <= '0;
            r_id         <= '0;
            r_ret_code   <= '0;
            r_drop       <= 1'b0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_first_byte <= n_first_byte;
            r_len_val    <= n_len_val;
            r_len_dig    <= n_len_dig;
            r_body_pos   <= n_body_pos;
            r_topic_len  <= n_topic_len;
            r_id         <= n_id;
            r_ret_code   <= n_ret_code;
            r_drop       <= n_drop;
            r_halted     <= n_halted;
        end
    end

endmodule

// ===== hw/rtl/mip_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// MQTT inbound packet parser: command queue
// Short register queue between the parsing front end and the result back
// end; the head is visible combinationally, without a read.
// ---------------------------------------------------------------------------
module mip_cmd_fifo #(
    parameter  int DEPTH = mip_pkg::CMD_FIFO_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mip_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output mip_pkg::t_cmd      o_head,
    output logic               o_head_valid,
    output logic               o_full,
    output logic [CNT_W-1:0]   o_level
);
    import mip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_level,  n_level;

    // Pointer and level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_level = r_level + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_level = r_level - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = r_level != '0;
    assign o_full       = r_level == CNT_W'(DEPTH);
    assign o_level      = r_level;

endmodule

// ===== hw/rtl/mip_back.sv =====
// ---------------------------------------------------------------------------
// MQTT inbound packet parser: back end
// Expands each queued command into one or two results and holds the oldest
// result in an output register until it is popped.
// ---------------------------------------------------------------------------
module mip_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  mip_pkg::t_cmd i_head,
    output logic          o_head_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [3:0]    o_event_res,
    output logic [7:0]    o_data_byte,
    output logic [3:0]    o_packet_type,
    output logic          o_qos_one,
    output logic          o_retain_flag,
    output logic [15:0]   o_message_id,
    output logic          o_ack_needed,
    output logic [15:0]   o_topic_bytes,
    output logic          o_last
);
    import mip_pkg::*;

    logic        r_out_valid;
    logic        r_sel;
    logic        load;
    logic [3:0]  sel_ev;
    logic        res_pub;
    logic        res_q;
    logic        res_done;
    logic        res_last;

    // Result selected from the head command
    always_comb begin
        sel_ev   = r_sel ? i_head.ev1 : i_head.ev0;
        res_pub  = (i_head.ptype == PKT_PUBLISH) && (sel_ev inside {[EV_TOPIC:EV_PUB_DONE]});
        res_q    = res_pub && i_head.qos1;
        res_done = sel_ev == EV_PUB_DONE;
        res_last = r_sel || !i_head.two;
    end

    // Load when the output register is free or being taken
    assign load       = i_head_valid && (!r_out_valid || i_pop);
    assign o_head_pop = load && res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_sel       <= !res_last;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_event_res   <= sel_ev;
            o_data_byte   <= r_sel ? 8'h00 : i_head.data;
            o_packet_type <= i_head.ptype;
            o_qos_one     <= res_q;
            o_retain_flag <= res_pub && i_head.retain;
            o_message_id  <= (res_done && res_q) ? i_head.id : 16'h0000;
            o_ack_needed  <= res_done && res_q;
            o_topic_bytes <= res_pub ? i_head.topic_len : 16'h0000;
            o_last        <= res_last;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

// ===== hw/rtl/mqtt_inbound_packet_parser.sv =====
// ---------------------------------------------------------------------------
// MQTT inbound packet parser
// Byte-stream parser for received MQTT 3.1.1 packets: fixed header, length
// varint, PUBLISH topic/payload streaming and CONNACK checking.
// ---------------------------------------------------------------------------
// Throughput: one byte accepted per cycle while full is low; the single output
//   register drains the command queue one result per pop.
// Path: an accepted byte's results pass through the command queue, then the
//   output register, before they reach the result ports.
// Reset: synchronous, active low; clears the parser, the command queue and the
//   output valid bit and sets max_packet_bytes to 4096. A halt lasts until reset.
// ---------------------------------------------------------------------------
`include "mqtt_inbound_packet_parser_defines.svh"

module mqtt_inbound_packet_parser #(
    parameter int CMD_DEPTH = mip_pkg::CMD_FIFO_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Byte input
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_rx_byte,
    // Results
    output logic                           empty,
    input  logic                           pop,
    output logic [3:0]                     o_event_res,
    output logic [7:0]                     o_data_byte,
    output logic [3:0]                     o_packet_type,
    output logic                           o_qos_one,
    output logic                           o_retain_flag,
    output logic [15:0]                    o_message_id,
    output logic                           o_ack_needed,
    output logic [15:0]                    o_topic_bytes,
    output logic                           o_last,
    // Configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mip_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mip_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mip_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mip_pkg::*;

    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    logic [LEN_W-1:0] r_max_pkt;
    logic             cfg_wr;
    logic             cfg_hit;
    logic             byte_accept;
    logic             cmd_valid;
    t_cmd             cmd;
    t_cmd             head;
    logic             head_valid;
    logic             head_pop;
    logic             front_halted;
    logic [CNT_W-1:0] fifo_level;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_hit = paddr[CFG_ADDR_W-1:2] == CFG_IDX_MAX_PKT;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_hit ? CFG_DATA_W'(r_max_pkt) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pkt <= MAX_PKT_RESET;
        end else if (cfg_wr && cfg_hit) begin
            r_max_pkt <= pwdata[LEN_W-1:0];
        end
    end

    // Input transfer
    assign byte_accept = push && !full;

    mip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (byte_accept),
        .i_rx_byte   (i_rx_byte),
        .i_max_pkt   (r_max_pkt),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_halted    (front_halted)
    );

    mip_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cmd_valid),
        .i_cmd        (cmd),
        .i_pop        (head_pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full),
        .o_level      (fifo_level)
    );

    mip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_head_pop    (head_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_event_res   (o_event_res),
        .o_data_byte   (o_data_byte),
        .o_packet_type (o_packet_type),
        .o_qos_one     (o_qos_one),
        .o_retain_flag (o_retain_flag),
        .o_message_id  (o_message_id),
        .o_ack_needed  (o_ack_needed),
        .o_topic_bytes (o_topic_bytes),
        .o_last        (o_last)
    );

    // Checks
    `MIP_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, front_halted, front_halted, "halt released")
    `MIP_ASSERT_NOW(a_halt_silent, i_clk, i_rst_n, front_halted, !cmd_valid, "result after halt")
    `MIP_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, 1'b1, fifo_level <= CNT_W'(CMD_DEPTH), "queue overrun")
    `MIP_ASSERT_NOW(a_ack_on_done, i_clk, i_rst_n, !empty && o_ack_needed, o_event_res == EV_PUB_DONE, "ack off done")

endmodule
